// File: rtl/bne_pkg.sv
// shared types, constants and helpers of the baseline noise estimator
`default_nettype none
package bne_pkg;

    localparam int DELAY_DEPTH = 65;
    localparam int DADDR_W     = 7;
    localparam int RUN_WIDTH   = 3;
    localparam int RUN_W       = 21;
    localparam int WIN_MIN     = 4;
    localparam int WIN_MAX     = 64;

    localparam logic [RUN_W-1:0] RUN_SAT  = {RUN_W{1'b1}};
    localparam logic [6:0]       WIN_RST  = 7'd5;
    localparam logic [15:0]      THR_RST  = 16'd20;

    // arithmetic unit operation codes
    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic [6:0] MUL_STEPS  = 7'd40;
    localparam logic [6:0] DIV_STEPS  = 7'd96;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    // register indexes
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_sts;

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        return (v != RUN_SAT) ? v + 1'b1 : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/bne_dline.sv
// sample delay line memory, one write and one registered read port
`default_nettype none
module bne_dline (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [bne_pkg::DADDR_W-1:0] i_waddr,
    input  wire logic signed [15:0]          i_wdata,
    input  wire logic [bne_pkg::DADDR_W-1:0] i_raddr,
    output logic signed [15:0]               o_rdata
);
    import bne_pkg::*;

    logic signed [15:0] r_mem [0:DELAY_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/bne_arith.sv
// shared serial multiply, divide and square root unit
`default_nettype none
module bne_arith (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bne_pkg::t_arith_req i_req,
    input  wire logic [95:0]         i_a,
    input  wire logic [63:0]         i_b,
    output bne_pkg::t_arith_sts      o_sts,
    output logic [95:0]              o_result
);
    import bne_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [1:0]  r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [95:0] r_x, n_x;
    logic [95:0] r_acc, n_acc;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_d, n_d;
    logic [64:0] rem_s;
    logic [64:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_d    = r_d;
        rem_s  = {r_rem[63:0], r_x[95]};
        trial  = {1'b0, r_acc[63:0]} + {1'b0, r_d};
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_op   = i_req.op;
                n_x    = i_a;
                n_acc  = '0;
                n_rem  = '0;
                n_d    = i_b;
                unique case (i_req.op)
                    OP_MUL:  n_cnt = MUL_STEPS;
                    OP_DIV:  n_cnt = DIV_STEPS;
                    OP_SQRT: begin
                        n_cnt = SQRT_STEPS;
                        n_rem = {1'b0, i_a[63:0]};
                        n_d   = 64'h4000_0000_0000_0000;
                    end
                    default: n_cnt = SQRT_STEPS;
                endcase
            end
        end else begin
            unique case (r_op)
                OP_MUL: begin
                    if (r_d[0]) begin
                        n_acc = r_acc + r_x;
                    end
                    n_x = {r_x[94:0], 1'b0};
                    n_d = {1'b0, r_d[63:1]};
                end
                OP_DIV: begin
                    n_x = {r_x[94:0], 1'b0};
                    if (rem_s >= {1'b0, r_d}) begin
                        n_rem = rem_s - {1'b0, r_d};
                        n_acc = {r_acc[94:0], 1'b1};
                    end else begin
                        n_rem = rem_s;
                        n_acc = {r_acc[94:0], 1'b0};
                    end
                end
                default: begin
                    // one digit of the bitwise square root
                    if (r_rem >= trial) begin
                        n_rem = r_rem - trial;
                        n_acc = {32'b0, ({1'b0, r_acc[63:1]} + r_d)};
                    end else begin
                        n_acc = {32'b0, 1'b0, r_acc[63:1]};
                    end
                    n_d = {2'b0, r_d[63:2]};
                end
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_result   = r_acc;

endmodule
`default_nettype wire

// File: rtl/baseline_noise_estimator_top.sv
// top level of the baseline noise estimator: stream ports, register port and sequencer
`default_nettype none
// Takes a record of signed 16-bit samples, one transfer each, closed by tlast. For every
// centre the 5-point derivative feeds an up/down/flat slope counter; while the quiet run is
// longer than window_len the sample 2*(window_len/2) back is added to the baseline set. The
// transfer with tlast produces one result transfer: total area, baseline mean and baseline
// RMS, all with 8 fractional bits (zeros for records shorter than window_len). Samples are
// kept in a 65-entry delay memory with a single read port, so an evaluated sample goes
// through accept, six tap reads, slope update and baseline update before the next is taken;
// the first 2*(window_len/2) samples of a record are only accepted. At record end a shared
// bit-serial unit runs a divide, three multiplies, a divide and a square root before the
// result is presented; a result waiting on the output does not block the next record's
// samples. Samples beyond 2^20 in one record are dropped but their tlast still closes it.
module baseline_noise_estimator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // sample stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    input  wire logic        s_axis_tlast,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // [44:0] total_area, [68:45] baseline,
                                             // [92:69] noise_rms, [95:93] zero
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bne_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_SLOPE = 4'd2;
    localparam logic [3:0] ST_BASE  = 4'd3;
    localparam logic [3:0] ST_FIN   = 4'd4;
    localparam logic [3:0] ST_BDIV  = 4'd5;
    localparam logic [3:0] ST_MQ    = 4'd6;
    localparam logic [3:0] ST_MS    = 4'd7;
    localparam logic [3:0] ST_MN    = 4'd8;
    localparam logic [3:0] ST_VDIV  = 4'd9;
    localparam logic [3:0] ST_SQRT  = 4'd10;
    localparam logic [3:0] ST_AMUL  = 4'd11;
    localparam logic [3:0] ST_AREA  = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    localparam logic signed [46:0] AREA_MAX = 47'sd17592186044415;
    localparam logic signed [46:0] AREA_MIN = -47'sd17592186044416;

    // registers
    logic [6:0]  r_win;
    logic [15:0] r_thr;

    // control
    logic [3:0]  r_state, n_state;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        r_issued, n_issued;
    logic        r_out_valid, n_out_valid;

    // record state
    logic [DADDR_W-1:0]     r_head, n_head;
    logic [RUN_W-1:0]       r_index, n_index;
    logic [RUN_W-1:0]       r_rise, n_rise, r_fall, n_fall;
    logic [RUN_W-1:0]       r_flat, n_flat, r_quiet, n_quiet;
    logic signed [37:0]     r_rsum, n_rsum, r_bsum, n_bsum;
    logic [51:0]            r_bsq, n_bsq;
    logic [RUN_W-1:0]       r_bcnt, n_bcnt;

    // working values of the end-of-record math
    logic signed [15:0] r_tap [0:4];
    logic [75:0]        r_p1, n_p1;
    logic [95:0]        r_v, n_v;
    logic [41:0]        r_nn, n_nn;
    logic signed [23:0] r_base, n_base;
    logic [23:0]        r_rms, n_rms;
    logic signed [45:0] r_prod, n_prod;
    logic signed [44:0] r_area, n_area;
    logic [95:0]        r_out, n_out;

    // datapath helpers
    logic               s_accept, m_take;
    logic [5:0]         half;
    logic [6:0]         back;
    logic [7:0]         diff;
    logic [DADDR_W-1:0] next_head, raddr;
    logic               we;
    logic signed [15:0] rdata;
    logic signed [19:0] num;
    logic signed [20:0] lim;
    logic [37:0]        abs_s;
    logic signed [31:0] bsq_term;
    logic signed [46:0] area_full;
    logic [75:0]        res76;
    logic               wait_st;
    t_arith_req         areq;
    t_arith_sts         asts;
    logic [95:0]        a_op;
    logic [63:0]        b_op;
    logic [95:0]        a_res;
    logic [6:0]         win_clamp;

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign m_take    = m_axis_tvalid && m_axis_tready;
    assign half      = r_win[6:1];
    assign next_head = (r_head == DADDR_W'(DELAY_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign we        = s_accept && !r_index[RUN_W-1];

    // tap offsets behind the newest sample
    always_comb begin
        unique case (r_cnt)
            3'd0:    back = {1'b0, half} - 7'd2;
            3'd1:    back = {1'b0, half} - 7'd1;
            3'd2:    back = {1'b0, half} + 7'd1;
            3'd3:    back = {1'b0, half} + 7'd2;
            default: back = {half, 1'b0};
        endcase
        diff  = {1'b0, r_head} - {1'b0, back};
        raddr = diff[7] ? DADDR_W'(diff + 8'(DELAY_DEPTH)) : diff[DADDR_W-1:0];
    end

    bne_dline u_dline (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (next_head),
        .i_wdata (s_axis_tdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // derivative times ten and the threshold times ten
    assign num = (20'(r_tap[1]) - 20'(r_tap[2])) + ((20'(r_tap[0]) - 20'(r_tap[3])) <<< 1);
    assign lim = $signed({1'b0, ({4'b0, r_thr} << 3) + ({4'b0, r_thr} << 1)});

    assign abs_s    = r_bsum[37] ? 38'(-r_bsum) : r_bsum;
    assign bsq_term = r_tap[4] * r_tap[4];
    assign res76    = a_res[75:0];

    assign wait_st = (r_state == ST_BDIV) || (r_state == ST_MQ) || (r_state == ST_MS) ||
                     (r_state == ST_MN) || (r_state == ST_VDIV) || (r_state == ST_SQRT);

    // operands of the shared unit for each step of the record-end math
    always_comb begin
        areq.start = wait_st && !r_issued;
        a_op    = '0;
        b_op    = '0;
        areq.op = OP_MUL;
        unique case (r_state)
            ST_BDIV: begin
                areq.op = OP_DIV;
                a_op    = 96'({abs_s, 9'b0}) + 96'(r_bcnt);
                b_op    = 64'({r_bcnt, 1'b0});
            end
            ST_MQ: begin
                a_op = 96'(r_bsq);
                b_op = 64'(r_bcnt);
            end
            ST_MS: begin
                a_op = 96'(abs_s);
                b_op = 64'(abs_s);
            end
            ST_MN: begin
                a_op = 96'(r_bcnt);
                b_op = 64'(r_bcnt);
            end
            ST_VDIV: begin
                areq.op = OP_DIV;
                a_op    = r_v;
                b_op    = 64'(r_nn);
            end
            ST_SQRT: begin
                areq.op = OP_SQRT;
                a_op    = {32'b0, r_v[63:0]};
            end
            default: begin
                a_op = '0;
            end
        endcase
    end

    bne_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (areq),
        .i_a      (a_op),
        .i_b      (b_op),
        .o_sts    (asts),
        .o_result (a_res)
    );

    assign area_full = ({{1{r_rsum[37]}}, r_rsum, 8'b0}) - 47'(r_prod);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_issued    = r_issued;
        n_out_valid = r_out_valid;
        n_head      = r_head;
        n_index     = r_index;
        n_rise      = r_rise;
        n_fall      = r_fall;
        n_flat      = r_flat;
        n_quiet     = r_quiet;
        n_rsum      = r_rsum;
        n_bsum      = r_bsum;
        n_bsq       = r_bsq;
        n_bcnt      = r_bcnt;
        n_p1        = r_p1;
        n_v         = r_v;
        n_nn        = r_nn;
        n_base      = r_base;
        n_rms       = r_rms;
        n_prod      = r_prod;
        n_area      = r_area;
        n_out       = r_out;

        if (m_take) begin
            n_out_valid = 1'b0;
        end
        if (areq.start) begin
            n_issued = 1'b1;
        end
        if (asts.done) begin
            n_issued = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_last = s_axis_tlast;
                    if (!r_index[RUN_W-1]) begin
                        n_head  = next_head;
                        n_index = r_index + 1'b1;
                        n_rsum  = r_rsum + 38'($signed(s_axis_tdata));
                        if (r_index >= RUN_W'({half, 1'b0})) begin
                            n_state = ST_RD;
                            n_cnt   = '0;
                        end else if (s_axis_tlast) begin
                            n_state = ST_FIN;
                        end
                    end else if (s_axis_tlast) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_RD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 3'd5) begin
                    n_state = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                if ($signed({num[19], num}) < -lim) begin
                    n_fall = sat_inc(r_fall);
                    n_rise = '0;
                    n_flat = '0;
                end else if ($signed({num[19], num}) > lim) begin
                    n_rise = sat_inc(r_rise);
                    n_fall = '0;
                    n_flat = '0;
                end else begin
                    n_flat = sat_inc(r_flat);
                    if (n_flat >= RUN_W'(2 * RUN_WIDTH)) begin
                        n_rise = '0;
                        n_fall = '0;
                    end
                end
                if (n_rise >= RUN_W'(RUN_WIDTH) || n_fall >= RUN_W'(RUN_WIDTH)) begin
                    n_quiet = '0;
                end else begin
                    n_quiet = sat_inc(r_quiet);
                end
                n_state = ST_BASE;
            end
            ST_BASE: begin
                if (r_quiet > RUN_W'(r_win)) begin
                    n_bsum = r_bsum + 38'(r_tap[4]);
                    n_bsq  = r_bsq + 52'(unsigned'(bsq_term));
                    n_bcnt = r_bcnt + 1'b1;
                end
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                n_base = '0;
                n_rms  = '0;
                n_area = '0;
                if (r_index < RUN_W'(r_win)) begin
                    n_state = ST_OUT;
                end else if (r_bcnt == '0) begin
                    n_state = ST_AMUL;
                end else begin
                    n_state = ST_BDIV;
                end
            end
            ST_BDIV: begin
                if (asts.done) begin
                    n_base  = r_bsum[37] ? -$signed(a_res[23:0]) : $signed(a_res[23:0]);
                    n_state = ST_MQ;
                end
            end
            ST_MQ: begin
                if (asts.done) begin
                    n_p1    = res76;
                    n_state = ST_MS;
                end
            end
            ST_MS: begin
                if (asts.done) begin
                    if (r_p1 <= res76) begin
                        n_state = ST_AMUL;
                    end else begin
                        n_v     = {4'b0, (r_p1 - res76), 16'b0};
                        n_state = ST_MN;
                    end
                end
            end
            ST_MN: begin
                if (asts.done) begin
                    n_nn    = a_res[41:0];
                    n_state = ST_VDIV;
                end
            end
            ST_VDIV: begin
                if (asts.done) begin
                    n_v     = a_res;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (asts.done) begin
                    n_rms   = a_res[23:0];
                    n_state = ST_AMUL;
                end
            end
            ST_AMUL: begin
                n_prod  = $signed({1'b0, r_index}) * r_base;
                n_state = ST_AREA;
            end
            ST_AREA: begin
                priority if (area_full > AREA_MAX) begin
                    n_area = AREA_MAX[44:0];
                end else if (area_full < AREA_MIN) begin
                    n_area = AREA_MIN[44:0];
                end else begin
                    n_area = area_full[44:0];
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out       = {3'b0, r_rms, r_base, r_area};
                    n_out_valid = 1'b1;
                    // record state back to its empty form
                    n_head  = '0;
                    n_index = '0;
                    n_rise  = '0;
                    n_fall  = '0;
                    n_flat  = '0;
                    n_quiet = '0;
                    n_rsum  = '0;
                    n_bsum  = '0;
                    n_bsq   = '0;
                    n_bcnt  = '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_index     <= '0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_flat      <= '0;
            r_quiet     <= '0;
            r_rsum      <= '0;
            r_bsum      <= '0;
            r_bsq       <= '0;
            r_bcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_index     <= n_index;
            r_rise      <= n_rise;
            r_fall      <= n_fall;
            r_flat      <= n_flat;
            r_quiet     <= n_quiet;
            r_rsum      <= n_rsum;
            r_bsum      <= n_bsum;
            r_bsq       <= n_bsq;
            r_bcnt      <= n_bcnt;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_p1   <= n_p1;
        r_v    <= n_v;
        r_nn   <= n_nn;
        r_base <= n_base;
        r_rms  <= n_rms;
        r_prod <= n_prod;
        r_area <= n_area;
        r_out  <= n_out;
        // tap capture in the cycle after each read address
        if (r_state == ST_RD && r_cnt != 3'd0) begin
            r_tap[r_cnt - 3'd1] <= rdata;
        end
    end

    // register port, clamp on window writes
    assign win_clamp = (pwdata[6:0] < 7'(WIN_MIN)) ? 7'(WIN_MIN) :
                       (pwdata[6:0] > 7'(WIN_MAX)) ? 7'(WIN_MAX) : pwdata[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RST;
            r_thr <= THR_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_WINDOW: r_win <= win_clamp;
                REG_THRESH: r_thr <= pwdata[15:0];
                default:    r_thr <= r_thr;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW: prdata = {25'b0, r_win};
            REG_THRESH: prdata = {16'b0, r_thr};
            default:    prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // a stalled result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !m_axis_tready) |=> (r_state == ST_OUT))
        else $error("result overwritten while stalled");

    // record state is empty after a result is loaded
    a_rec_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && n_state == ST_IDLE) |=> (r_index == '0 && r_bcnt == '0))
        else $error("record state not cleared");

    // baseline set never exceeds the samples taken
    a_bcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bcnt <= r_index)
        else $error("baseline count above sample count");

    // the shared unit is only started when free
    a_arith: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        areq.start |-> !asts.busy)
        else $error("arithmetic unit started while busy");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// self-checking testbench of the baseline noise estimator
`timescale 1ns / 100ps
module testbench;
    import bne_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  REC_CAP     = 1048576;
    localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [2:0] ADDR_THRESH = {REG_THRESH, 2'b00};

    typedef struct {
        logic signed [44:0] area;
        logic signed [23:0] level;
        logic        [23:0] rms;
    } t_summary;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] sample
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // [44:0] total_area, [68:45] baseline, [92:69] noise_rms
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    baseline_noise_estimator_top u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: registers and one open record
    int          win_len = 5;
    int          slope_thr = 20;
    int          rec_samples[$];
    longint      rec_len, rise_cnt, fall_cnt, flat_cnt, quiet_cnt, base_cnt;
    longint      rec_sum, base_sum;
    longint unsigned base_sq;
    t_summary    pending_summaries[$];

    int          err_count = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic longint run_inc(input longint v);
        return (v < 64'd2097151) ? v + 1 : v;
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned baseline_rms();
        logic [127:0] a, b, v, d;
        longint unsigned s;
        s = (base_sum < 0) ? -base_sum : base_sum;
        a = 128'(base_cnt) * 128'(base_sq);
        b = 128'(s) * 128'(s);
        if (a <= b) return 0;
        v = (a - b) << 16;
        d = 128'(base_cnt) * 128'(base_cnt);
        return isqrt(64'(v / d));
    endfunction

    function automatic void clear_record();
        rec_samples.delete();
        rec_len = 0; rise_cnt = 0; fall_cnt = 0; flat_cnt = 0; quiet_cnt = 0;
        base_cnt = 0; rec_sum = 0; base_sum = 0; base_sq = 0;
    endfunction

    // sample `back` positions behind the newest one
    function automatic longint tap(input int back);
        return rec_samples[rec_samples.size() - 1 - back];
    endfunction

    function automatic void predict_sample(input int smp, input bit last);
        int h;
        longint num, lim, b, lvl, area;
        t_summary res;
        if (rec_len < REC_CAP) begin
            h = win_len / 2;
            rec_samples.insert(rec_samples.size(), smp);
            rec_len++;
            rec_sum += smp;
            if (rec_len - 1 >= 2 * h) begin
                num = tap(h - 1) - tap(h + 1) + 2 * (tap(h - 2) - tap(h + 2));
                lim = 10 * longint'(slope_thr);
                if (num < -lim) begin
                    fall_cnt = run_inc(fall_cnt);
                    rise_cnt = 0; flat_cnt = 0;
                end else if (num > lim) begin
                    rise_cnt = run_inc(rise_cnt);
                    fall_cnt = 0; flat_cnt = 0;
                end else begin
                    flat_cnt = run_inc(flat_cnt);
                    if (flat_cnt >= 2 * RUN_WIDTH) begin
                        rise_cnt = 0; fall_cnt = 0;
                    end
                end
                if (rise_cnt >= RUN_WIDTH || fall_cnt >= RUN_WIDTH) quiet_cnt = 0;
                else quiet_cnt = run_inc(quiet_cnt);
                if (quiet_cnt > win_len) begin
                    b = tap(2 * h);
                    base_sum += b;
                    base_sq += longint'(b * b);
                    base_cnt++;
                end
            end
        end
        if (!last) return;
        res.area = '0; res.level = '0; res.rms = '0;
        if (rec_len >= win_len) begin
            lvl = 0;
            if (base_cnt != 0) begin
                b = ((base_sum < 0) ? -base_sum : base_sum) * 256;
                lvl = (2 * b + base_cnt) / (2 * base_cnt);
                if (base_sum < 0) lvl = -lvl;
                res.rms = 24'(baseline_rms());
            end
            area = rec_sum * 256 - rec_len * lvl;
            if (area > 64'sd17592186044415) area = 64'sd17592186044415;
            if (area < -64'sd17592186044416) area = -64'sd17592186044416;
            res.area = 45'(area);
            res.level = 24'(lvl);
        end
        pending_summaries.insert(pending_summaries.size(), res);
        clear_record();
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_summary want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_summaries.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                want = pending_summaries.pop_front();
                if (m_axis_tdata[44:0] !== want.area)
                    report("total_area", $signed(m_axis_tdata[44:0]), want.area);
                if (m_axis_tdata[68:45] !== want.level)
                    report("baseline", $signed(m_axis_tdata[68:45]), want.level);
                if (m_axis_tdata[92:69] !== want.rms)
                    report("noise_rms", m_axis_tdata[92:69], want.rms);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk)
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 27);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_sample(input int smp, input bit last);
        while (!no_idle && $urandom_range(0, 99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 16'(smp);
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_sample(smp, last);
        items_sent++;
    endtask

    // sender holds off until every result is back, then lets the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_WINDOW) begin
            win_len = data[6:0];
            if (win_len < WIN_MIN) win_len = WIN_MIN;
            if (win_len > WIN_MAX) win_len = WIN_MAX;
        end else begin
            slope_thr = data[15:0];
        end
    endtask

    function automatic int clip16(input int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // one record: quiet baseline with noise and an occasional pulse, or raw noise
    task automatic send_record(input int len);
        int lvl, amp, pk_at, pk_h, v, mode;
        mode  = $urandom_range(0, 99);
        lvl   = $urandom_range(0, 60000) - 30000;
        amp   = $urandom_range(0, 40);
        pk_at = $urandom_range(0, len);
        pk_h  = $urandom_range(0, 20000) - 10000;
        for (int i = 0; i < len; i++) begin
            if (mode < 20) begin
                v = $signed(16'($urandom));
            end else begin
                v = lvl + $urandom_range(0, 2 * amp) - amp;
                if (i >= pk_at && i < pk_at + 6) v += pk_h;
            end
            send_sample(clip16(v), i == len - 1);
        end
    endtask

    task automatic test_directed();
        // extremes at reset window, a single-sample and a short record
        send_sample(-32768, 0); send_sample(32767, 0); send_sample(0, 0);
        send_sample(-1, 0);     send_sample(1, 1);
        send_sample(32767, 1);
        send_sample(5, 0); send_sample(-5, 0); send_sample(7, 0); send_sample(9, 1);
        // flat record that qualifies a baseline
        for (int i = 0; i < 14; i++) send_sample(-32768, i == 13);
        drain();
    endtask

    task automatic test_window_sweep();
        logic [31:0] wins[6] = '{0, 127, 64, 4, 7, 32};
        foreach (wins[i]) begin
            write_reg(ADDR_WINDOW, wins[i]);
            repeat (2) send_record($urandom_range(1, 60));
            send_record(win_len - 1);
            send_record(win_len);
            drain();
        end
    endtask

    task automatic test_threshold();
        logic [31:0] thrs[4] = '{0, 65535, 3, 20};
        foreach (thrs[i]) begin
            write_reg(ADDR_THRESH, thrs[i]);
            repeat (2) send_record($urandom_range(10, 100));
            drain();
        end
    endtask

    task automatic test_random();
        int phase_start;
        bit first;
        first = 1'b1;
        do begin
            if ($urandom_range(0, 1)) write_reg(ADDR_WINDOW, $urandom_range(0, 127));
            if ($urandom_range(0, 2) == 0) write_reg(ADDR_THRESH, $urandom_range(0, 65535));
            else write_reg(ADDR_THRESH, $urandom_range(0, 60));
            // the first phase runs with no idling on either side
            no_idle = first || ($urandom_range(0, 3) == 0);
            first = 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < 250) begin
                if ($urandom_range(0, 99) < 15) send_record($urandom_range(1, win_len));
                else send_record($urandom_range(win_len, 120));
            end
            drain();
        end while (items_sent < 1700);
        no_idle = 1'b0;
    endtask

    initial begin
        clear_record();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_window_sweep();
        test_threshold();
        test_random();
        drain();
        repeat (400) @(posedge i_clk);
        if (err_count == 0 && pending_summaries.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
